[hdl/satq_pkg.sv]
// ----------------------------------------------------------------------------
// satq_pkg - shared definitions for the sorted alarm timer queue
// Sizes, status codes and the control/status bundles between FSM and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package satq_pkg;

	localparam int QUEUE_DEPTH = 16;
	// handles are 4 bits wide, so at most 16 usable slots
	localparam int SLOTS       = (QUEUE_DEPTH < 16) ? QUEUE_DEPTH : 16;
	localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int OCC_W       = $clog2(SLOTS + 1);

	localparam int CNT_W    = 32;
	localparam int DUR_W    = 32;
	localparam int CPU_W    = 8;
	localparam int HANDLE_W = 4;
	localparam int STATUS_W = 2;

	localparam logic [CPU_W-1:0] CPU_RESET = 8'd168;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE    = 2'd0,
		ST_CREATED = 2'd1,
		ST_FULL    = 2'd2,
		ST_FIRED   = 2'd3
	} status_t;

	// commands from controller to datapath
	typedef struct packed {
		logic load_in;   // capture accepted item
		logic tick;      // advance counter, check head, post result
		logic reject;    // post queue-full result
		logic calc_len;  // duration * cycles_per_us, clear search pointer
		logic step;      // advance search pointer
		logic insert;    // write new entry, post created result
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic             func;
		logic             full;
		logic             search_done;
		logic             out_busy;
		logic [OCC_W-1:0] occ;
	} sts_t;

endpackage

`default_nettype wire

[hdl/sorted_alarm_timer_queue.sv]
// ----------------------------------------------------------------------------
// sorted_alarm_timer_queue - ordered one-shot alarm queue on a cycle counter
// Tick items advance the counter and retire the head when due; create items
// insert an alarm in order of remaining cycles and return its slot handle, or report full.
// ----------------------------------------------------------------------------
// Sequence: tick and queue-full create post their result from EXEC into the
// result register; a create runs EXEC (length), SEARCH (0..occupancy entries
// walked, one per cycle) and INSERT; posting waits while the output is held.
// Throughput: one item at a time; the next transfer is taken once the item
// finishes, while its result may still wait in the output register.
// Reset: counter 0, queue empty, all slots free, cycles_per_us = 168.
`default_nettype none

module sorted_alarm_timer_queue (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [satq_pkg::CPU_W-1:0]    cfg_wdata,   // cycles_per_us
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [31:0]                   s_tdata,     // [31:0] duration_us
	input  wire logic                          s_tuser,     // [0] func
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [7:0]                         m_tdata,     // [3:0] handle, [7:4] zero
	output logic [1:0]                         m_tuser      // [1:0] status
);

	satq_pkg::cmd_t    cmd;
	satq_pkg::sts_t    sts;
	satq_pkg::status_t out_status;
	logic [satq_pkg::HANDLE_W-1:0] out_handle;

	satq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	satq_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_func    (s_tuser),
		.in_dur     (s_tdata),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (out_status),
		.out_handle (out_handle)
	);

	assign m_tdata = {4'b0000, out_handle};
	assign m_tuser = out_status;

	// one item in flight: no transfer right after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in progress");

	// no-result and full results carry a zero handle
	a_zero_handle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == satq_pkg::ST_NONE || m_tuser == satq_pkg::ST_FULL)
		|-> m_tdata == 8'h00)
		else $error("handle not zero on empty result");

	// occupancy never exceeds slot count
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.occ <= satq_pkg::OCC_W'(satq_pkg::SLOTS))
		else $error("queue occupancy out of range");

	// a create result appears only after an insert with room in the queue
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !sts.full)
		else $error("insert into full queue");

endmodule

`default_nettype wire

[hdl/satq_ctrl.sv]
// ----------------------------------------------------------------------------
// satq_ctrl - sequencing FSM
// Accepts one item, runs tick or create (length calc, ordered search, insert).
// ----------------------------------------------------------------------------
`default_nettype none

module satq_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire satq_pkg::sts_t sts,
	output satq_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_EXEC   = 4'b0010,
		S_SEARCH = 4'b0100,
		S_INSERT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!sts.func) begin
					if (!sts.out_busy) begin
						cmd.tick = 1'b1;
						state_d  = S_IDLE;
					end
				end else if (sts.full) begin
					if (!sts.out_busy) begin
						cmd.reject = 1'b1;
						state_d    = S_IDLE;
					end
				end else begin
					cmd.calc_len = 1'b1;
					state_d      = S_SEARCH;
				end
			end
			S_SEARCH: begin
				if (sts.search_done) begin
					state_d = S_INSERT;
				end else begin
					cmd.step = 1'b1;
				end
			end
			S_INSERT: begin
				if (!sts.out_busy) begin
					cmd.insert = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[hdl/satq_dp.sv]
// ----------------------------------------------------------------------------
// satq_dp - timer queue datapath
// Cycle counter, ordered entry queue, slot map, search pointer, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module satq_dp (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_we,
	input  wire logic [satq_pkg::CPU_W-1:0]           cfg_wdata,
	input  wire logic                                 in_func,
	input  wire logic [satq_pkg::DUR_W-1:0]           in_dur,
	input  wire satq_pkg::cmd_t                       cmd,
	output satq_pkg::sts_t                            sts,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output satq_pkg::status_t                         out_status,
	output logic [satq_pkg::HANDLE_W-1:0]             out_handle
);

	logic [satq_pkg::CPU_W-1:0]  cpu_q;
	logic [satq_pkg::CNT_W-1:0]  cnt_q;
	logic                        func_q;
	logic [satq_pkg::DUR_W-1:0]  dur_q;
	logic [satq_pkg::CNT_W-1:0]  len_q;
	logic [satq_pkg::OCC_W-1:0]  pos_q;
	logic [satq_pkg::OCC_W-1:0]  occ_q;
	logic [satq_pkg::SLOTS-1:0]  free_q;

	logic [satq_pkg::CNT_W-1:0]  start_q  [satq_pkg::SLOTS];
	logic [satq_pkg::CNT_W-1:0]  length_q [satq_pkg::SLOTS];
	logic [satq_pkg::SLOT_W-1:0] hndl_q   [satq_pkg::SLOTS];

	logic                        out_valid_q;
	satq_pkg::status_t           out_status_q;
	logic [satq_pkg::HANDLE_W-1:0] out_handle_q;

	logic [satq_pkg::SLOT_W-1:0] free_idx;
	logic [satq_pkg::SLOT_W-1:0] pos_idx;
	logic [satq_pkg::CNT_W-1:0]  cnt_next;
	logic [satq_pkg::CNT_W-1:0]  head_elapsed;
	logic                        fire;
	logic [satq_pkg::CNT_W-1:0]  srch_elapsed;
	logic [satq_pkg::CNT_W-1:0]  srch_rem;
	logic                        full;
	logic                        out_busy;

	// lowest free slot
	always_comb begin
		free_idx = '0;
		for (int i = satq_pkg::SLOTS - 1; i >= 0; i--) begin
			if (free_q[i]) free_idx = satq_pkg::SLOT_W'(i);
		end
	end

	assign full     = (occ_q >= satq_pkg::OCC_W'(satq_pkg::SLOTS));
	assign out_busy = out_valid_q && !out_ready;

	// head check uses the advanced count
	assign cnt_next     = cnt_q + 1'b1;
	assign head_elapsed = cnt_next - start_q[0];
	assign fire         = (occ_q != '0) && (head_elapsed >= length_q[0]);

	// walk: stop at first entry whose remaining cycles exceed the new length;
	// overdue entries count as zero remaining
	assign pos_idx      = pos_q[satq_pkg::SLOT_W-1:0];
	assign srch_elapsed = cnt_q - start_q[pos_idx];
	assign srch_rem     = length_q[pos_idx] - srch_elapsed;

	always_comb begin
		sts.func        = func_q;
		sts.full        = full;
		sts.out_busy    = out_busy;
		sts.occ         = occ_q;
		sts.search_done = (pos_q == occ_q) ||
		                  ((srch_elapsed < length_q[pos_idx]) && (srch_rem > len_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_q  <= satq_pkg::CPU_RESET;
			cnt_q  <= '0;
			occ_q  <= '0;
			free_q <= '1;
		end else begin
			if (cfg_we) cpu_q <= cfg_wdata;
			if (cmd.tick) begin
				cnt_q <= cnt_next;
				if (fire) begin
					occ_q             <= occ_q - 1'b1;
					free_q[hndl_q[0]] <= 1'b1;
				end
			end
			if (cmd.insert) begin
				occ_q            <= occ_q + 1'b1;
				free_q[free_idx] <= 1'b0;
			end
		end
	end

	// item and search registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			func_q <= in_func;
			dur_q  <= in_dur;
		end
		if (cmd.calc_len) begin
			len_q <= dur_q * satq_pkg::DUR_W'(cpu_q);
			pos_q <= '0;
		end else if (cmd.step) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	// queue storage: pop shifts toward the head, insert shifts away from it
	for (genvar k = 0; k < satq_pkg::SLOTS; k++) begin : g_entry
		always_ff @(posedge clk) begin
			if (cmd.tick && fire) begin
				if (k < satq_pkg::SLOTS - 1) begin
					start_q[k]  <= start_q[(k + 1) % satq_pkg::SLOTS];
					length_q[k] <= length_q[(k + 1) % satq_pkg::SLOTS];
					hndl_q[k]   <= hndl_q[(k + 1) % satq_pkg::SLOTS];
				end
			end else if (cmd.insert) begin
				if (satq_pkg::OCC_W'(k) == pos_q) begin
					start_q[k]  <= cnt_q;
					length_q[k] <= len_q;
					hndl_q[k]   <= free_idx;
				end else if (k > 0 && satq_pkg::OCC_W'(k) > pos_q &&
				             satq_pkg::OCC_W'(k) <= occ_q) begin
					start_q[k]  <= start_q[(k + satq_pkg::SLOTS - 1) % satq_pkg::SLOTS];
					length_q[k] <= length_q[(k + satq_pkg::SLOTS - 1) % satq_pkg::SLOTS];
					hndl_q[k]   <= hndl_q[(k + satq_pkg::SLOTS - 1) % satq_pkg::SLOTS];
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.tick || cmd.reject || cmd.insert) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick) begin
			out_status_q <= fire ? satq_pkg::ST_FIRED : satq_pkg::ST_NONE;
			out_handle_q <= fire ? satq_pkg::HANDLE_W'(hndl_q[0]) : '0;
		end else if (cmd.reject) begin
			out_status_q <= satq_pkg::ST_FULL;
			out_handle_q <= '0;
		end else if (cmd.insert) begin
			out_status_q <= satq_pkg::ST_CREATED;
			out_handle_q <= satq_pkg::HANDLE_W'(free_idx);
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_handle = out_handle_q;

endmodule

`default_nettype wire
